// ===== hdl/dcs_pkg.sv =====
// Shared types, constants and helper functions for the display-scan clock.
`default_nettype none

package dcs_pkg;

  // Bit positions of the buttons inside a packed level or latch vector.
  localparam int unsigned BtnPush  = 0;
  localparam int unsigned BtnLeft  = 1;
  localparam int unsigned BtnRight = 2;
  localparam int unsigned BtnFront = 3;
  localparam int unsigned BtnBack  = 4;

  localparam logic [9:0] TicksPerSecondReset = 10'd1000;

  localparam logic [5:0] SecondsPerMinute = 6'd60;
  localparam logic [6:0] MinutesPerHour   = 7'd60;
  localparam logic [4:0] HoursPerDay      = 5'd24;

  localparam logic [4:0] PresetHours   = 5'd23;
  localparam logic [6:0] PresetMinutes = 7'd59;
  localparam logic [5:0] PresetSeconds = 6'd45;
  localparam logic [6:0] FrontMinutes  = 7'd5;

  // Scan phases, in display order.
  localparam logic [2:0] ScanLeftTens   = 3'd0;
  localparam logic [2:0] ScanLeftUnits  = 3'd1;
  localparam logic [2:0] ScanPoint      = 3'd2;
  localparam logic [2:0] ScanRightTens  = 3'd3;
  localparam logic [2:0] ScanRightUnits = 3'd4;
  localparam logic [2:0] ScanSteps      = 3'd5;

  // Digit drive codes, bit 0 is the leftmost digit.
  localparam logic [3:0] DigitZero  = 4'b0001;
  localparam logic [3:0] DigitOne   = 4'b0010;
  localparam logic [3:0] DigitTwo   = 4'b0100;
  localparam logic [3:0] DigitThree = 4'b1000;

  // Pattern index for the decimal point alone.
  localparam logic [3:0] PatternPoint = 4'd10;

  // Button levels, active low; bit 0 is push.
  typedef struct packed {
    logic back_n;
    logic front_n;
    logic right_n;
    logic left_n;
    logic push_n;
  } btn_t;

  // Time and mode after one tick has been applied.
  typedef struct packed {
    logic [4:0] hours;
    logic [6:0] minutes;
    logic [5:0] seconds;
    logic       show_ms;
  } time_t;

  // Seven-segment pattern, segments a..g in bits 0..6, point in bit 7.
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h3F;
      4'd1:    pat = 8'h06;
      4'd2:    pat = 8'h5B;
      4'd3:    pat = 8'h4F;
      4'd4:    pat = 8'h66;
      4'd5:    pat = 8'h6D;
      4'd6:    pat = 8'h7D;
      4'd7:    pat = 8'h07;
      4'd8:    pat = 8'h7F;
      4'd9:    pat = 8'h6F;
      default: pat = 8'h80;
    endcase
    return pat;
  endfunction

  // Tens digit of a 7-bit value: multiply by 205 and drop 11 bits.
  function automatic logic [3:0] tens_of(input logic [6:0] value);
    logic [14:0] prod;
    prod = {8'd0, value} * 15'd205;
    return prod[14:11];
  endfunction

  // Units digit of a 7-bit value.
  function automatic logic [3:0] units_of(input logic [6:0] value);
    logic [6:0] rest;
    rest = value - 7'(tens_of(value)) * 7'd10;
    return rest[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/dcs_core.sv =====
// Timekeeping core: tick counter, time counters, button latches and mode.
`default_nettype none

module dcs_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire dcs_pkg::btn_t    btn_i,
  input  wire logic [9:0]       tps_i,
  output dcs_pkg::time_t        time_o
);

  logic [4:0] hour_q, hour_d;
  logic [6:0] min_q, min_d;
  logic [5:0] sec_q, sec_d;
  logic [9:0] tick_q, tick_d;
  logic [4:0] latch_q, latch_d;
  logic       mode_q, mode_d;

  logic [9:0] tick_v;
  logic [4:0] lvl;
  logic [4:0] press;

  always_comb begin
    tick_v = tick_q;
    hour_d = hour_q;
    min_d  = min_q;
    sec_d  = sec_q;

    // Advance seconds, then ripple carries, including a late carry.
    if (tick_v >= tps_i) begin
      sec_d  = sec_d + 6'd1;
      tick_v = '0;
    end
    if (sec_d >= dcs_pkg::SecondsPerMinute) begin
      min_d = min_d + 7'd1;
      sec_d = '0;
    end
    if (min_d >= dcs_pkg::MinutesPerHour) begin
      hour_d = hour_d + 5'd1;
      min_d  = '0;
      sec_d  = '0;
    end
    if (hour_d >= dcs_pkg::HoursPerDay) begin
      hour_d = '0;
      min_d  = '0;
      sec_d  = '0;
    end

    // A button acts once per hold: pressed now and not latched.
    lvl     = btn_i;
    press   = ~lvl & ~latch_q;
    latch_d = ~lvl;

    if (press[dcs_pkg::BtnPush]) begin
      hour_d = '0;
      min_d  = '0;
      sec_d  = '0;
    end
    mode_d = mode_q ^ press[dcs_pkg::BtnLeft] ^ press[dcs_pkg::BtnRight];
    if (press[dcs_pkg::BtnBack]) begin
      hour_d = dcs_pkg::PresetHours;
      min_d  = dcs_pkg::PresetMinutes;
      sec_d  = dcs_pkg::PresetSeconds;
    end
    if (press[dcs_pkg::BtnFront]) begin
      if (mode_d) begin
        min_d = min_d + dcs_pkg::FrontMinutes;
      end else begin
        hour_d = hour_d + 5'd1;
      end
    end

    tick_d = tick_v + 10'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q  <= '0;
      min_q   <= '0;
      sec_q   <= '0;
      tick_q  <= '0;
      latch_q <= '0;
      mode_q  <= 1'b1;
    end else if (step_i) begin
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
      tick_q  <= tick_d;
      latch_q <= latch_d;
      mode_q  <= mode_d;
    end
  end

  always_comb begin
    time_o.hours   = hour_d;
    time_o.minutes = min_d;
    time_o.seconds = sec_d;
    time_o.show_ms = mode_d;
  end

endmodule

`default_nettype wire

// ===== hdl/dcs_scan.sv =====
// Display scan: phase counter and digit/segment selection.
`default_nettype none

module dcs_scan (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire dcs_pkg::time_t   time_i,
  output logic [3:0]            digit_o,
  output logic [7:0]            seg_o
);

  logic [2:0] phase_q, phase_d;
  logic [2:0] phase_v;
  logic [6:0] left_pair;
  logic [6:0] right_pair;

  always_comb begin
    phase_v = (phase_q >= dcs_pkg::ScanSteps) ? dcs_pkg::ScanLeftTens : phase_q;
    left_pair  = time_i.show_ms ? time_i.minutes : {2'b00, time_i.hours};
    right_pair = time_i.show_ms ? {1'b0, time_i.seconds} : time_i.minutes;

    unique case (phase_v)
      dcs_pkg::ScanLeftTens: begin
        digit_o = dcs_pkg::DigitZero;
        seg_o   = dcs_pkg::seg_pattern(dcs_pkg::tens_of(left_pair));
      end
      dcs_pkg::ScanLeftUnits: begin
        digit_o = dcs_pkg::DigitOne;
        seg_o   = dcs_pkg::seg_pattern(dcs_pkg::units_of(left_pair));
      end
      dcs_pkg::ScanPoint: begin
        digit_o = dcs_pkg::DigitOne;
        seg_o   = dcs_pkg::seg_pattern(dcs_pkg::PatternPoint);
      end
      dcs_pkg::ScanRightTens: begin
        digit_o = dcs_pkg::DigitTwo;
        seg_o   = dcs_pkg::seg_pattern(dcs_pkg::tens_of(right_pair));
      end
      default: begin
        digit_o = dcs_pkg::DigitThree;
        seg_o   = dcs_pkg::seg_pattern(dcs_pkg::units_of(right_pair));
      end
    endcase

    phase_d = phase_v + 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dcs_pkg::ScanLeftTens;
    end else if (step_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/digital_clock_with_display_scan_unit.sv =====
// Top level of the multiplexed seven-segment clock with its handshake stages.
// Flow: a tick taken into the input register moves into the result register when that register is free or emptying.
// Throughput: one tick per cycle while the result side does not stall; the time update and the scan decode for a tick
// are settled combinationally between the input register and the result register.
// Reset: asynchronous, active low; time 00:00:00, MM:SS mode, threshold 1000,
// scan phase zero, no button held, both stages empty.
`default_nettype none

module digital_clock_with_display_scan_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write channel: the seconds threshold.
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [9:0] cfg_ticks_per_second_i,
  // Tick input channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       push_n_i,
  input  wire logic       left_n_i,
  input  wire logic       right_n_i,
  input  wire logic       front_n_i,
  input  wire logic       back_n_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [3:0]      digit_enable_o,
  output logic [7:0]      segment_bits_o,
  output logic [4:0]      hours_now_o,
  output logic [6:0]      minutes_now_o,
  output logic [5:0]      seconds_now_o,
  output logic            show_minutes_seconds_o
);

  // The threshold register is always writable; software must write it only
  // while no tick transaction is in flight, which the block does not enforce.
  logic [9:0] tps_q;

  // Input register: one tick transaction waiting to be applied.
  logic          in_valid_q;
  dcs_pkg::btn_t btn_q;

  // Result register.
  logic        out_valid_q;
  logic [3:0]  digit_q;
  logic [7:0]  seg_q;
  logic [4:0]  hours_q;
  logic [6:0]  minutes_q;
  logic [5:0]  seconds_q;
  logic        show_ms_q;

  logic           step;
  logic           in_accept;
  dcs_pkg::time_t time_next;
  logic [3:0]     digit_next;
  logic [7:0]     seg_next;

  // A held tick is applied when the result register is empty or is being
  // emptied in this cycle. Applying it commits all clock state at once, so
  // each tick sees exactly the state its predecessor left behind.
  assign step        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !step;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= dcs_pkg::TicksPerSecondReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tps_q <= cfg_ticks_per_second_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      btn_q.push_n  <= push_n_i;
      btn_q.left_n  <= left_n_i;
      btn_q.right_n <= right_n_i;
      btn_q.front_n <= front_n_i;
      btn_q.back_n  <= back_n_i;
    end
  end

  dcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .btn_i  (btn_q),
    .tps_i  (tps_q),
    .time_o (time_next)
  );

  dcs_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .time_i  (time_next),
    .digit_o (digit_next),
    .seg_o   (seg_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      digit_q   <= digit_next;
      seg_q     <= seg_next;
      hours_q   <= time_next.hours;
      minutes_q <= time_next.minutes;
      seconds_q <= time_next.seconds;
      show_ms_q <= time_next.show_ms;
    end
  end

  assign out_valid_o            = out_valid_q;
  assign digit_enable_o         = digit_q;
  assign segment_bits_o         = seg_q;
  assign hours_now_o            = hours_q;
  assign minutes_now_o          = minutes_q;
  assign seconds_now_o          = seconds_q;
  assign show_minutes_seconds_o = show_ms_q;

  // Exactly one digit is driven for every delivered result.
  a_digit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(digit_q))
    else $error("digit enable is not one-hot");

  // Seconds always carry within the tick that reaches sixty.
  a_seconds_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (seconds_q < dcs_pkg::SecondsPerMinute))
    else $error("seconds out of range");

  // Hours may reach the day length only through a front press, never beyond.
  a_hours_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (hours_q <= dcs_pkg::HoursPerDay))
    else $error("hours out of range");

  // A tick that is applied always leaves a result in the result register.
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("applied tick produced no result");

  // The input side stalls only while a tick is held and cannot move on.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

endmodule

`default_nettype wire
